/* rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants of the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int SCREEN_ROWS_DEFAULT = 25;
   localparam int SCREEN_COLS_DEFAULT = 80;

   localparam int CELL_WIDTH = 16;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_ERROR   = 8'd69;
   localparam logic [7:0] PLAIN_ATTR = 8'h0F;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_TEXT_ATTR  = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ERROR_ATTR = 3'd4;

   localparam logic [7:0] TEXT_ATTR_RESET  = 8'd15;
   localparam logic [7:0] ERROR_ATTR_RESET = 8'd244;

endpackage

/* rtl/text_console_char_writer_core.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer_core
// Character-cell text console: screen memory, cursor and request sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. kind selects
//   character write, screen clear or cell read. Every request gives one
//   result, shown for one cycle with rsp_valid; the receiver cannot stall.
//   Steps from the accepting edge to the strobe:
//     character write            address, write, scroll walk if it scrolls
//     newline                    address, scroll walk if it scrolls
//     off-screen write, read     address, write/read (off-screen read: none)
//     clear                      walk over every cell
//     unused kind                straight to the result
//   busy drops with the strobe, so a new request may follow in that cycle.
//   No new request is taken until the last result is out; the memory's one
//   write port sets the scroll and clear walks at one cell a cycle.
//   Attribute registers sit on the APB port at 0 (text) and 4 (error).
//   Reset clears cursor and sequencer and presets the attribute registers;
//   the screen holds undefined data until the first clear.
// ----------------------------------------------------------------------------
module text_console_char_writer_core #(
   parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEFAULT,
   parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_kind,
   input  logic [7:0]                         req_char_code,
   input  logic                               req_place_here,
   input  logic [5:0]                         req_pos_row,
   input  logic [7:0]                         req_pos_col,
   output logic                               rsp_valid,
   output logic [4:0]                         rsp_cursor_line,
   output logic [6:0]                         rsp_cursor_column,
   output logic                               rsp_scrolled,
   output logic                               rsp_out_of_range,
   output logic [7:0]                         rsp_cell_char,
   output logic [7:0]                         rsp_cell_attr,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tcw_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import tcw_pkg::*;

   localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
   localparam int MOVE_COUNT = CELL_COUNT - SCREEN_COLS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int CTW        = $clog2(CELL_COUNT + 1);
   localparam int RW         = $clog2(SCREEN_ROWS);
   localparam int CW         = $clog2(SCREEN_COLS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADDR,
      S_WRITE,
      S_READ,
      S_SCROLL,
      S_FILL,
      S_CLEAR,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [RW-1:0]         crow_ff, crow_in;
   logic [CW-1:0]         ccol_ff, ccol_in;
   logic [RW-1:0]         trow_ff, trow_in;
   logic [CW-1:0]         tcol_ff, tcol_in;
   logic [1:0]            op_ff, op_in;
   logic                  oor_ff, oor_in;
   logic                  is_nl_ff, is_nl_in;
   logic                  scrolled_ff, scrolled_in;
   logic                  cell_ok_ff, cell_ok_in;
   logic [CELL_WIDTH-1:0] wdata_ff, wdata_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [CTW-1:0]        cnt_ff, cnt_in;
   logic                  mv_pend_ff, mv_pend_in;
   logic [AW-1:0]         mv_addr_ff, mv_addr_in;
   logic [7:0]            text_attr_ff, text_attr_in;
   logic [7:0]            error_attr_ff, error_attr_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [4:0]            rsp_line_ff, rsp_line_in;
   logic [6:0]            rsp_column_ff, rsp_column_in;
   logic                  rsp_scrolled_ff, rsp_scrolled_in;
   logic                  rsp_oor_ff, rsp_oor_in;
   logic [7:0]            rsp_char_ff, rsp_char_in;
   logic [7:0]            rsp_attr_ff, rsp_attr_in;

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [CELL_WIDTH-1:0] mem_wr_data;
   logic [AW-1:0]         mem_rd_addr;
   logic [CELL_WIDTH-1:0] mem_rd_data;

   logic                  accept;
   logic                  pos_in_range;
   logic                  row_end;
   logic                  last_row;
   logic [7:0]            char_attr;
   logic                  csr_write;

   tcw_screen_store #(
      .DEPTH (CELL_COUNT),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign accept       = start && (state_ff == S_IDLE);
   assign busy         = (state_ff != S_IDLE);
   assign pos_in_range = ({1'b0, req_pos_row} < 7'(SCREEN_ROWS)) &&
                         ({1'b0, req_pos_col} < 9'(SCREEN_COLS));
   assign row_end      = is_nl_ff || (tcol_ff == CW'(SCREEN_COLS - 1));
   assign last_row     = (trow_ff == RW'(SCREEN_ROWS - 1));
   assign char_attr    = (text_attr_ff != 8'd0) ? text_attr_ff : PLAIN_ATTR;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      text_attr_in  = text_attr_ff;
      error_attr_in = error_attr_ff;
      if (csr_write) begin
         unique case (paddr[2])
            CSR_ERROR_ATTR[2]: error_attr_in = pwdata[7:0];
            default:           text_attr_in  = pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_ERROR_ATTR[2]: prdata = {24'd0, error_attr_ff};
         default:           prdata = {24'd0, text_attr_ff};
      endcase
   end

   // memory port selection
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = wdata_ff;
      mem_rd_addr = addr_ff;
      unique case (state_ff)
         S_WRITE: begin
            mem_wr_en = 1'b1;
         end
         S_SCROLL: begin
            mem_wr_en   = mv_pend_ff;
            mem_wr_addr = mv_addr_ff;
            mem_wr_data = mem_rd_data;
            mem_rd_addr = AW'(cnt_ff + CTW'(SCREEN_COLS));
         end
         S_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff[AW-1:0];
            mem_wr_data = '0;
         end
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff[AW-1:0];
            mem_wr_data = {PLAIN_ATTR, CH_SPACE};
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      crow_in         = crow_ff;
      ccol_in         = ccol_ff;
      trow_in         = trow_ff;
      tcol_in         = tcol_ff;
      op_in           = op_ff;
      oor_in          = oor_ff;
      is_nl_in        = is_nl_ff;
      scrolled_in     = scrolled_ff;
      cell_ok_in      = cell_ok_ff;
      wdata_in        = wdata_ff;
      addr_in         = addr_ff;
      cnt_in          = cnt_ff;
      mv_pend_in      = 1'b0;
      mv_addr_in      = mv_addr_ff;
      rsp_valid_in    = 1'b0;
      rsp_line_in     = rsp_line_ff;
      rsp_column_in   = rsp_column_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_oor_in      = rsp_oor_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_attr_in     = rsp_attr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in       = req_kind;
               oor_in      = 1'b0;
               is_nl_in    = 1'b0;
               scrolled_in = 1'b0;
               cell_ok_in  = 1'b0;
               cnt_in      = '0;
               case (req_kind)
                  KIND_WRITE: begin
                     oor_in   = req_place_here && !pos_in_range;
                     trow_in  = req_place_here ? req_pos_row[RW-1:0] : crow_ff;
                     tcol_in  = req_place_here ? req_pos_col[CW-1:0] : ccol_ff;
                     is_nl_in = (req_char_code == CH_NEWLINE) &&
                                !(req_place_here && !pos_in_range);
                     wdata_in = (req_place_here && !pos_in_range) ?
                                {error_attr_ff, CH_ERROR} : {char_attr, req_char_code};
                     state_in = S_ADDR;
                  end
                  KIND_CLEAR: begin
                     crow_in  = '0;
                     ccol_in  = '0;
                     state_in = S_CLEAR;
                  end
                  KIND_READ: begin
                     trow_in    = req_pos_row[RW-1:0];
                     tcol_in    = req_pos_col[CW-1:0];
                     cell_ok_in = pos_in_range;
                     state_in   = pos_in_range ? S_ADDR : S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_ADDR: begin
            addr_in = oor_ff ? AW'(CELL_COUNT - 1) :
                      AW'(AW'(trow_ff) * AW'(SCREEN_COLS) + AW'(tcol_ff));
            if (op_ff == KIND_READ) begin
               state_in = S_READ;
            end else if (oor_ff) begin
               state_in = S_WRITE;
            end else begin
               if (row_end) begin
                  ccol_in     = '0;
                  crow_in     = last_row ? trow_ff : RW'(trow_ff + RW'(1));
                  scrolled_in = last_row;
               end else begin
                  ccol_in = CW'(tcol_ff + CW'(1));
                  crow_in = trow_ff;
               end
               if (!is_nl_ff) begin
                  state_in = S_WRITE;
               end else begin
                  state_in = (row_end && last_row) ? S_SCROLL : S_DONE;
               end
            end
         end
         S_WRITE: begin
            state_in = scrolled_ff ? S_SCROLL : S_DONE;
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_SCROLL: begin
            if (cnt_ff < CTW'(MOVE_COUNT)) begin
               mv_pend_in = 1'b1;
               mv_addr_in = cnt_ff[AW-1:0];
               cnt_in     = CTW'(cnt_ff + CTW'(1));
            end else begin
               cnt_in   = CTW'(MOVE_COUNT);
               state_in = S_FILL;
            end
         end
         S_FILL, S_CLEAR: begin
            if (cnt_ff == CTW'(CELL_COUNT - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = CTW'(cnt_ff + CTW'(1));
            end
         end
         S_DONE: begin
            rsp_valid_in    = 1'b1;
            rsp_line_in     = 5'(crow_ff);
            rsp_column_in   = 7'(ccol_ff);
            rsp_scrolled_in = scrolled_ff;
            rsp_oor_in      = oor_ff;
            rsp_char_in     = cell_ok_ff ? mem_rd_data[7:0]  : 8'd0;
            rsp_attr_in     = cell_ok_ff ? mem_rd_data[15:8] : 8'd0;
            state_in        = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         crow_ff       <= '0;
         ccol_ff       <= '0;
         mv_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         text_attr_ff  <= TEXT_ATTR_RESET;
         error_attr_ff <= ERROR_ATTR_RESET;
      end else begin
         state_ff      <= state_in;
         crow_ff       <= crow_in;
         ccol_ff       <= ccol_in;
         mv_pend_ff    <= mv_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         text_attr_ff  <= text_attr_in;
         error_attr_ff <= error_attr_in;
      end
      trow_ff         <= trow_in;
      tcol_ff         <= tcol_in;
      op_ff           <= op_in;
      oor_ff          <= oor_in;
      is_nl_ff        <= is_nl_in;
      scrolled_ff     <= scrolled_in;
      cell_ok_ff      <= cell_ok_in;
      wdata_ff        <= wdata_in;
      addr_ff         <= addr_in;
      cnt_ff          <= cnt_in;
      mv_addr_ff      <= mv_addr_in;
      rsp_line_ff     <= rsp_line_in;
      rsp_column_ff   <= rsp_column_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_oor_ff      <= rsp_oor_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_attr_ff     <= rsp_attr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_line   = rsp_line_ff;
   assign rsp_cursor_column = rsp_column_ff;
   assign rsp_scrolled      = rsp_scrolled_ff;
   assign rsp_out_of_range  = rsp_oor_ff;
   assign rsp_cell_char     = rsp_char_ff;
   assign rsp_cell_attr     = rsp_attr_ff;

endmodule

/* rtl/tcw_screen_store.sv */
// ----------------------------------------------------------------------------
// tcw_screen_store
// Screen cell memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen_store #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [AW-1:0]                 wr_addr,
   input  logic [tcw_pkg::CELL_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]                 rd_addr,
   output logic [tcw_pkg::CELL_WIDTH-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_WIDTH-1:0] cells_ff [DEPTH];
   logic [CELL_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= cells_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console character writer.
// ----------------------------------------------------------------------------
module tcw_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_scrolled,
   input logic       rsp_out_of_range,
   input logic [7:0] rsp_cell_char,
   input logic [7:0] rsp_cell_attr
);

   // accepted request occupies the block
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy low after accepted request");

   // result only at the end of a request
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without request in progress");

   // busy drops exactly with the result strobe
   a_fell_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("request ended without result");

   // an error mark never scrolls nor reads a cell
   a_oor_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |->
         !rsp_scrolled && rsp_cell_char == 8'd0 && rsp_cell_attr == 8'd0)
      else $error("off-screen write result carries other flags");

endmodule

bind text_console_char_writer_core tcw_checker u_tcw_checker (.*);

/* tb/text_console_char_writer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_core_tb
// Self-checking bench for the text console character writer. A tracker holds
// its own screen, cursor and attribute registers, predicts the status of each
// accepted request and checks every strobed response against it. A directed
// run covers screen edges, newlines, scrolls, off-screen writes and reads,
// then four random phases vary the attribute registers and the request gaps.
// ----------------------------------------------------------------------------
module text_console_char_writer_core_tb;
   import tcw_pkg::*;

   localparam int ROWS  = SCREEN_ROWS_DEFAULT;
   localparam int COLS  = SCREEN_COLS_DEFAULT;
   localparam int CELLS = ROWS * COLS;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int PHASE_ITEMS = 325;
   localparam int PHASES      = 4;
   localparam int DIRECTED    = 25;
   localparam longint LIMIT_CYCLES =
      longint'(PHASES * PHASE_ITEMS + DIRECTED) * (CELLS + 64) * 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_code;
      logic       place_here;
      logic [5:0] pos_row;
      logic [7:0] pos_col;
   } request_type;

   typedef struct packed {
      logic [4:0] line;
      logic [6:0] column;
      logic       scrolled;
      logic       out_of_range;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
   } status_type;

   class screen_tracker;
      logic [15:0] screen [CELLS];
      int unsigned cursor_cell;
      logic [7:0]  text_attr;
      logic [7:0]  error_attr;
      status_type  awaited_status [$];
      int          failures;

      function new();
         cursor_cell = 0;
         text_attr   = TEXT_ATTR_RESET;
         error_attr  = ERROR_ATTR_RESET;
         failures    = 0;
         foreach (screen[i]) screen[i] = '0;
      endfunction

      function status_type predict_status(request_type r);
         status_type  s;
         int unsigned pos;
         logic [7:0]  attr;
         s = '0;
         case (r.kind)
            KIND_WRITE: begin
               if (r.place_here && (r.pos_row >= ROWS || r.pos_col >= COLS)) begin
                  screen[CELLS-1] = {error_attr, CH_ERROR};
                  s.out_of_range = 1'b1;
               end else begin
                  pos  = r.place_here ? r.pos_row * COLS + r.pos_col : cursor_cell;
                  attr = (text_attr != 8'd0) ? text_attr : PLAIN_ATTR;
                  if (r.char_code == CH_NEWLINE) begin
                     pos = (pos / COLS + 1) * COLS;
                  end else begin
                     screen[pos] = {attr, r.char_code};
                     pos++;
                  end
                  if (pos >= CELLS) begin
                     for (int i = 0; i + COLS < CELLS; i++) screen[i] = screen[i+COLS];
                     for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = '0;
                     pos -= COLS;
                     s.scrolled = 1'b1;
                  end
                  cursor_cell = pos;
               end
            end
            KIND_CLEAR: begin
               foreach (screen[i]) screen[i] = {PLAIN_ATTR, CH_SPACE};
               cursor_cell = 0;
            end
            KIND_READ: begin
               if (r.pos_row < ROWS && r.pos_col < COLS)
                  {s.cell_attr, s.cell_char} = screen[r.pos_row * COLS + r.pos_col];
            end
            default: ;
         endcase
         s.line   = 5'(cursor_cell / COLS);
         s.column = 7'(cursor_cell % COLS);
         return s;
      endfunction

      function void note_request(request_type r);
         awaited_status.push_back(predict_status(r));
      endfunction

      function void compare_field(string name, int unsigned exp, int unsigned act);
         if (exp != act) begin
            $error("%s: expected %0d, actual %0d", name, exp, act);
            failures++;
         end
      endfunction

      function void check_response(status_type got);
         status_type exp;
         if (awaited_status.size() == 0) begin
            $error("response with no request awaiting it");
            failures++;
            return;
         end
         exp = awaited_status.pop_front();
         compare_field("cursor_line", exp.line, got.line);
         compare_field("cursor_column", exp.column, got.column);
         compare_field("scrolled", exp.scrolled, got.scrolled);
         compare_field("out_of_range", exp.out_of_range, got.out_of_range);
         compare_field("cell_char", exp.cell_char, got.cell_char);
         compare_field("cell_attr", exp.cell_attr, got.cell_attr);
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic [1:0]                req_kind;
   logic [7:0]                req_char_code;
   logic                      req_place_here;
   logic [5:0]                req_pos_row;
   logic [7:0]                req_pos_col;
   logic                      rsp_valid;
   logic [4:0]                rsp_cursor_line;
   logic [6:0]                rsp_cursor_column;
   logic                      rsp_scrolled;
   logic                      rsp_out_of_range;
   logic [7:0]                rsp_cell_char;
   logic [7:0]                rsp_cell_attr;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;

   screen_tracker tracker = new();
   longint        cycle_count = 0;
   request_type   directed_reqs [$];

   text_console_char_writer_core #(
      .SCREEN_ROWS(ROWS),
      .SCREEN_COLS(COLS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_char_code     (req_char_code),
      .req_place_here    (req_place_here),
      .req_pos_row       (req_pos_row),
      .req_pos_col       (req_pos_col),
      .rsp_valid         (rsp_valid),
      .rsp_cursor_line   (rsp_cursor_line),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_scrolled      (rsp_scrolled),
      .rsp_out_of_range  (rsp_out_of_range),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         tracker.check_response({rsp_cursor_line, rsp_cursor_column, rsp_scrolled,
                                 rsp_out_of_range, rsp_cell_char, rsp_cell_attr});
   end

   function automatic request_type make_request(logic [1:0] k, logic [7:0] c, logic h,
                                                logic [5:0] r, logic [7:0] col);
      request_type q;
      q.kind       = k;
      q.char_code  = c;
      q.place_here = h;
      q.pos_row    = r;
      q.pos_col    = col;
      return q;
   endfunction

   function automatic request_type random_request(int unsigned cursor_row);
      request_type r;
      int unsigned pick;
      r.char_code  = ($urandom_range(99) < 8) ? CH_NEWLINE : 8'($urandom);
      r.place_here = 1'($urandom);
      r.pos_row    = ($urandom_range(99) < 85) ? 6'($urandom_range(ROWS-1)) : 6'($urandom);
      r.pos_col    = ($urandom_range(99) < 85) ? 8'($urandom_range(COLS-1)) : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 55) begin
         r.kind = KIND_WRITE;
         // aim at the last cell now and then to force a scroll
         if (r.place_here && $urandom_range(99) < 10) begin
            r.pos_row = 6'(ROWS - 1);
            r.pos_col = 8'(COLS - 1);
         end
      end else if (pick < 88) begin
         r.kind = KIND_READ;
         if ($urandom_range(99) < 40) r.pos_row = 6'(cursor_row);
      end else if (pick < 91) begin
         r.kind = KIND_CLEAR;
      end else begin
         r.kind = KIND_UNUSED;
      end
      return r;
   endfunction

   task automatic issue(request_type r);
      @(negedge clock);
      start          <= 1'b1;
      req_kind       <= r.kind;
      req_char_code  <= r.char_code;
      req_place_here <= r.place_here;
      req_pos_row    <= r.pos_row;
      req_pos_col    <= r.pos_col;
      do @(posedge clock); while (busy);
      tracker.note_request(r);
   endtask

   task automatic sender_pause(int unsigned pct);
      if ($urandom_range(99) < pct) begin
         @(negedge clock);
         start          <= 1'b0;
         req_kind       <= 2'($urandom);
         req_char_code  <= 8'($urandom);
         req_place_here <= 1'($urandom);
         req_pos_row    <= 6'($urandom);
         req_pos_col    <= 8'($urandom);
         while ($urandom_range(99) < pct) @(negedge clock);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.awaited_status.size() > 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_WIDTH-1:0] addr, logic [7:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {24'd0, value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_expect(logic [CSR_ADDR_WIDTH-1:0] addr, logic [7:0] exp);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] != exp) begin
         $error("register %0d: expected %0d, actual %0d", addr, exp, prdata[7:0]);
         tracker.failures++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_attrs(logic [7:0] text, logic [7:0] err);
      csr_write(CSR_TEXT_ATTR, text);
      csr_write(CSR_ERROR_ATTR, err);
      tracker.text_attr  = text;
      tracker.error_attr = err;
   endtask

   initial begin
      int unsigned idle_pct [PHASES];
      logic [7:0]  phase_text [PHASES];
      logic [7:0]  phase_err [PHASES];

      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = KIND_WRITE;
      req_char_code  = 8'd0;
      req_place_here = 1'b0;
      req_pos_row    = 6'd0;
      req_pos_col    = 8'd0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = CSR_TEXT_ATTR;
      pwdata         = 32'd0;

      idle_pct   = '{0, 82, 0, 8};
      phase_text = '{8'hFF, 8'($urandom), 8'($urandom), 8'h00};
      phase_err  = '{8'h00, 8'($urandom), 8'($urandom), 8'($urandom)};

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      csr_expect(CSR_TEXT_ATTR, TEXT_ATTR_RESET);
      csr_expect(CSR_ERROR_ATTR, ERROR_ATTR_RESET);
      set_attrs(8'h00, 8'hFF);

      directed_reqs.push_back(make_request(KIND_UNUSED, 8'hFF, 1'b1, 6'h3F, 8'hFF));
      directed_reqs.push_back(make_request(KIND_CLEAR, 8'h00, 1'b0, 6'd0, 8'd0));
      directed_reqs.push_back(make_request(KIND_WRITE, 8'h41, 1'b0, 6'd0, 8'd0));
      directed_reqs.push_back(make_request(KIND_WRITE, 8'hFF, 1'b0, 6'h3F, 8'hFF));
      directed_reqs.push_back(make_request(KIND_WRITE, 8'h00, 1'b1, 6'd0, 8'd0));
      directed_reqs.push_back(make_request(KIND_READ, 8'h00, 1'b0, 6'd0, 8'd0));
      directed_reqs.push_back(make_request(KIND_READ, 8'hFF, 1'b1, 6'd0, 8'd1));
      directed_reqs.push_back(make_request(KIND_WRITE, CH_NEWLINE, 1'b0, 6'd0, 8'd0));
      directed_reqs.push_back(make_request(KIND_WRITE, 8'h7A, 1'b1, 6'(ROWS-1), 8'(COLS-1)));
      directed_reqs.push_back(make_request(KIND_READ, 8'h00, 1'b0, 6'(ROWS-2), 8'(COLS-1)));
      directed_reqs.push_back(make_request(KIND_READ, 8'h00, 1'b0, 6'(ROWS-1), 8'd0));
      directed_reqs.push_back(make_request(KIND_WRITE, CH_NEWLINE, 1'b1, 6'(ROWS-1), 8'd5));
      directed_reqs.push_back(make_request(KIND_WRITE, 8'h71, 1'b1, 6'(ROWS), 8'd0));
      directed_reqs.push_back(make_request(KIND_WRITE, CH_NEWLINE, 1'b1, 6'h3F, 8'hFF));
      directed_reqs.push_back(make_request(KIND_WRITE, 8'h72, 1'b1, 6'd0, 8'(COLS)));
      directed_reqs.push_back(make_request(KIND_READ, 8'h00, 1'b0, 6'(ROWS-1), 8'(COLS-1)));
      directed_reqs.push_back(make_request(KIND_READ, 8'h00, 1'b0, 6'(ROWS), 8'(COLS-1)));
      directed_reqs.push_back(make_request(KIND_READ, 8'h00, 1'b1, 6'h3F, 8'hFF));
      directed_reqs.push_back(make_request(KIND_READ, 8'h00, 1'b0, 6'd0, 8'(COLS)));
      directed_reqs.push_back(make_request(KIND_WRITE, 8'h78, 1'b1, 6'(ROWS-1), 8'(COLS-2)));
      directed_reqs.push_back(make_request(KIND_WRITE, 8'h79, 1'b0, 6'd0, 8'd0));
      directed_reqs.push_back(make_request(KIND_WRITE, CH_NEWLINE, 1'b0, 6'd0, 8'd0));
      directed_reqs.push_back(make_request(KIND_READ, 8'h00, 1'b0, 6'(ROWS-3), 8'(COLS-1)));
      directed_reqs.push_back(make_request(KIND_CLEAR, 8'hFF, 1'b1, 6'h3F, 8'hFF));
      directed_reqs.push_back(make_request(KIND_READ, 8'hFF, 1'b0, 6'(ROWS-1), 8'(COLS-1)));

      foreach (directed_reqs[i]) issue(directed_reqs[i]);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         set_attrs(phase_text[p], phase_err[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            issue(random_request(tracker.cursor_cell / COLS));
            sender_pause(idle_pct[p]);
         end
         settle();
      end

      // drain: a late scroll or clear walk may still be running
      repeat (CELLS + 8) @(posedge clock);

      if (tracker.failures == 0 && tracker.awaited_status.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/tcw_pkg.sv
rtl/tcw_screen_store.sv
rtl/text_console_char_writer_core.sv
rtl/tcw_checker.sv
tb/text_console_char_writer_core_tb.sv
